/* src/sa_pkg.sv */
// Shared types and constants for the stable argsort block.
// Used by sa_cell and stable_argsort_top; depends on nothing.
`default_nettype none

package sa_pkg;

  // width of an arrival index on the result side
  localparam int unsigned IDX_W = 6;

  // result tdata: arrival index, zero-filled to a whole byte
  localparam int unsigned OUT_TDATA_W = 8;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load;        // insert the incoming key this cycle
    logic drain;       // shift the chain toward cell 0 by one place
    logic descending;  // sort direction for the compare
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/sa_cell.sv */
// One cell of the insertion chain: holds one key and its arrival index.
// Depends on sa_pkg for the control struct and the index width.
`default_nettype none

module sa_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire sa_pkg::cell_ctl_t           ctl,
  input  wire logic                        occ,       // this cell holds a stored key
  input  wire logic signed [KEY_WIDTH-1:0] new_key,
  input  wire logic [sa_pkg::IDX_W-1:0]    new_idx,
  input  wire logic signed [KEY_WIDTH-1:0] prev_key,  // from the cell one rank lower
  input  wire logic [sa_pkg::IDX_W-1:0]    prev_idx,
  input  wire logic                        prev_ins,
  input  wire logic signed [KEY_WIDTH-1:0] next_key,  // from the cell one rank higher
  input  wire logic [sa_pkg::IDX_W-1:0]    next_idx,
  output logic signed [KEY_WIDTH-1:0]      key,
  output logic [sa_pkg::IDX_W-1:0]         idx,
  output logic                             ins
);

  logic signed [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [sa_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                          hit;

  // new key lands at or below this cell: empty cell, or stored key ranks after it.
  // Equal keys never move, so later arrivals stay behind earlier ones.
  assign hit = !occ || (ctl.descending ? (key_r < new_key) : (key_r > new_key));

  // cell moves once any lower cell has taken the insert point, so the upper part of
  // the chain shifts as a block even after a direction change within a run
  assign ins = prev_ins || hit;

  // insert: first moving cell takes the new key, the rest take their lower neighbor
  always_comb begin
    key_nxt = key_r;
    idx_nxt = idx_r;
    priority if (ctl.load && ins) begin
      key_nxt = prev_ins ? prev_key : new_key;
      idx_nxt = prev_ins ? prev_idx : new_idx;
    end else if (ctl.drain) begin
      key_nxt = next_key;
      idx_nxt = next_idx;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    idx_r <= idx_nxt;
  end

  assign key = key_r;
  assign idx = idx_r;

endmodule

`default_nettype wire

/* src/stable_argsort_top.sv */
// Stable argsort: a chain of MAX_ITEMS insertion cells, one stored key each.
// Loading: one key per cycle, each that fits placed in the chain in the cycle it is
// accepted. Readout: starts the cycle after the last item; N indices, one per cycle
// while out_tready is high, shifted out of cell 0. Input is held off during readout.
// Reset (rst_n low, synchronous) empties the store, clears overflow and sets ascending.
// Depends on sa_pkg and sa_cell.
`default_nettype none

module stable_argsort_top #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // key stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [31:0]                    in_tdata,   // [31:0] key (signed Q16.16)
  input  wire logic                           in_tlast,   // last_item
  // sorted index stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sa_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [5:0] arrival_index
  output logic                                out_tlast,  // last_of_run
  output logic [0:0]                          out_tuser,  // [0] overflow
  // direction register
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_data    // descending
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             drain_r, drain_nxt;
  logic             desc_r;

  logic                        in_acc, out_acc, room, final_out;
  logic signed [KEY_WIDTH-1:0] key_ext;
  logic [sa_pkg::IDX_W-1:0]    new_idx;
  sa_pkg::cell_ctl_t           ctl;

  logic signed [KEY_WIDTH-1:0] c_key [MAX_ITEMS];
  logic [sa_pkg::IDX_W-1:0]    c_idx [MAX_ITEMS];
  logic                        c_ins [MAX_ITEMS];

  // key taken from the low KEY_WIDTH bits, sign-extended when wider than the port
  if (KEY_WIDTH <= 32) begin : g_key_narrow
    assign key_ext = $signed(in_tdata[KEY_WIDTH-1:0]);
  end else begin : g_key_wide
    assign key_ext = $signed({{(KEY_WIDTH-32){in_tdata[31]}}, in_tdata});
  end

  // handshakes
  assign in_tready = !drain_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign room      = count_r < CNT_W'(MAX_ITEMS);
  assign final_out = out_acc && out_tlast;
  assign cfg_ready = 1'b1;
  assign new_idx   = sa_pkg::IDX_W'(count_r);

  assign ctl.load       = in_acc && room;
  assign ctl.drain      = out_acc;
  assign ctl.descending = desc_r;

  // insertion cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                        occ;
    logic signed [KEY_WIDTH-1:0] p_key, n_key;
    logic [sa_pkg::IDX_W-1:0]    p_idx, n_idx;
    logic                        p_ins;

    assign occ = CNT_W'(i) < count_r;

    if (i == 0) begin : g_first
      assign p_key = '0;
      assign p_idx = '0;
      assign p_ins = 1'b0;
    end else begin : g_inner
      assign p_key = c_key[i-1];
      assign p_idx = c_idx[i-1];
      assign p_ins = c_ins[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign n_key = '0;
      assign n_idx = '0;
    end else begin : g_mid
      assign n_key = c_key[i+1];
      assign n_idx = c_idx[i+1];
    end

    sa_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ),
      .new_key  (key_ext),
      .new_idx  (new_idx),
      .prev_key (p_key),
      .prev_idx (p_idx),
      .prev_ins (p_ins),
      .next_key (n_key),
      .next_idx (n_idx),
      .key      (c_key[i]),
      .idx      (c_idx[i]),
      .ins      (c_ins[i])
    );
  end

  // fill count doubles as the readout countdown
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    drain_nxt   = drain_r;
    priority if (final_out) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
      drain_nxt   = 1'b0;
    end else if (out_acc) begin
      count_nxt = count_r - 1'b1;
    end else if (in_acc) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
      drain_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      drain_r   <= 1'b0;
      desc_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      drain_r   <= drain_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
    end
  end

  // result comes straight from cell 0
  assign out_tvalid = drain_r;
  assign out_tdata  = sa_pkg::OUT_TDATA_W'(c_idx[0]);
  assign out_tlast  = count_r == CNT_W'(1);
  assign out_tuser  = dropped_r;

endmodule

`default_nettype wire

/* src/sa_checker.sv */
// Port-level checks for stable_argsort_top, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module sa_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [0:0] out_tuser
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // readout begins right after the closing item
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no readout after last item");

  // no keys are taken while indices are going out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken during readout");

  // the run ends on its last index and overflow holds within it
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("readout continues past last index");

  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> $stable(out_tuser))
    else $error("overflow flag changed within a run");

endmodule

bind stable_argsort_top sa_checker u_sa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
